FILE: rtl/core/cpu8_alu_with_flags_defines.svh
// ---------------------------------------------------------------------------
// cpu8_alu_with_flags_defines.svh
// Assertion macros shared by the ALU core files. Each macro expects signals
// named clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef CPU8_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU8_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C8A_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C8A_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/core/c8a_pkg.sv
// ---------------------------------------------------------------------------
// c8a_pkg
// Operation codes, constants and beat payload types of the 8-bit ALU.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package c8a_pkg;

	localparam int unsigned KIND_W = 5;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BIDX_W = 3;

	typedef enum logic [KIND_W-1:0] {
		OP_ADD      = 5'd0,
		OP_ADC      = 5'd1,
		OP_SUB      = 5'd2,
		OP_SBC      = 5'd3,
		OP_AND      = 5'd4,
		OP_XOR      = 5'd5,
		OP_OR       = 5'd6,
		OP_CP       = 5'd7,
		OP_INC      = 5'd8,
		OP_DEC      = 5'd9,
		OP_DAA      = 5'd10,
		OP_CPL      = 5'd11,
		OP_CCF      = 5'd12,
		OP_SCF      = 5'd13,
		OP_SWAP     = 5'd14,
		OP_BIT      = 5'd15,
		OP_SET      = 5'd16,
		OP_RES      = 5'd17,
		OP_RLC      = 5'd18,
		OP_RL       = 5'd19,
		OP_RRC      = 5'd20,
		OP_RR       = 5'd21,
		OP_SLA      = 5'd22,
		OP_SRA      = 5'd23,
		OP_SRL      = 5'd24,
		OP_ADD16    = 5'd25,
		OP_ADD_SP_E = 5'd26,
		OP_RLCA     = 5'd27,
		OP_RLA      = 5'd28,
		OP_RRCA     = 5'd29,
		OP_RRA      = 5'd30
	} kind_t;

	// Decimal adjust constants
	localparam logic [BYTE_W-1:0] DAA_ADJ_HI = 8'h60;
	localparam logic [BYTE_W-1:0] DAA_ADJ_LO = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_MAX_HI = 8'h99;
	localparam logic [3:0]        DAA_MAX_LO = 4'h9;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
		logic [BIDX_W-1:0] bit_index;
		logic              zero_in;
		logic              sub_in;
		logic              half_in;
		logic              carry_in;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              write_result;
		logic              zero_out;
		logic              sub_out;
		logic              half_out;
		logic              carry_out;
	} rsp_item_t;

endpackage

FILE: rtl/core/c8a_if.sv
// ---------------------------------------------------------------------------
// c8a_if
// Valid/ready channels for ALU request and response beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface c8a_req_if;
	import c8a_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [WORD_W-1:0] operand_a;
	logic [WORD_W-1:0] operand_b;
	logic [BIDX_W-1:0] bit_index;
	logic              zero_in;
	logic              sub_in;
	logic              half_in;
	logic              carry_in;

	modport source (
		output valid, kind, operand_a, operand_b, bit_index,
		output zero_in, sub_in, half_in, carry_in,
		input  ready
	);

	modport sink (
		input  valid, kind, operand_a, operand_b, bit_index,
		input  zero_in, sub_in, half_in, carry_in,
		output ready
	);
endinterface

interface c8a_rsp_if;
	import c8a_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result;
	logic              write_result;
	logic              zero_out;
	logic              sub_out;
	logic              half_out;
	logic              carry_out;

	modport source (
		output valid, result, write_result, zero_out, sub_out, half_out, carry_out,
		input  ready
	);

	modport sink (
		input  valid, result, write_result, zero_out, sub_out, half_out, carry_out,
		output ready
	);
endinterface

FILE: rtl/core/c8a_alu.sv
// ---------------------------------------------------------------------------
// c8a_alu
// Combinational datapath: one request beat in, result and flags out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8a_alu (
	input  c8a_pkg::req_item_t req_item,
	output c8a_pkg::rsp_item_t rsp_item
);
	import c8a_pkg::*;

	logic [BYTE_W-1:0] a;
	logic [BYTE_W-1:0] b;
	logic [WORD_W-1:0] a16;
	logic [WORD_W-1:0] b16;
	kind_t             op;

	logic              add_cy;
	logic              sub_cy;
	logic [BYTE_W:0]   add9;
	logic [4:0]        add_nib;
	logic [BYTE_W:0]   sub9;
	logic [4:0]        sub_nib;
	logic [WORD_W:0]   add17;
	logic [12:0]       add13;
	logic [BYTE_W:0]   sp_lo9;
	logic [4:0]        sp_nib;
	logic              daa_hi;
	logic              daa_lo;
	logic [BYTE_W-1:0] bit_mask;

	logic [BYTE_W-1:0] r8;
	logic [WORD_W-1:0] r16;
	logic              wide;
	logic              setz;
	logic              wr;
	logic              z;
	logic              n;
	logic              h;
	logic              c;

	assign a16 = req_item.operand_a;
	assign b16 = req_item.operand_b;
	assign a   = a16[BYTE_W-1:0];
	assign b   = b16[BYTE_W-1:0];
	assign op  = kind_t'(req_item.kind);

	assign add_cy  = (op == OP_ADC) ? req_item.carry_in : 1'b0;
	assign sub_cy  = (op == OP_SBC) ? req_item.carry_in : 1'b0;
	assign add9    = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, add_cy};
	assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cy};
	assign sub9    = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, sub_cy};
	assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cy};
	assign add17   = {1'b0, a16} + {1'b0, b16};
	assign add13   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
	assign sp_lo9  = {1'b0, a16[BYTE_W-1:0]} + {1'b0, b};
	assign sp_nib  = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
	assign daa_hi  = req_item.carry_in || (a > DAA_MAX_HI);
	assign daa_lo  = req_item.half_in || (a[3:0] > DAA_MAX_LO);
	assign bit_mask = BYTE_W'(1) << req_item.bit_index;

	always_comb begin
		r8   = '0;
		r16  = '0;
		wide = 1'b0;
		setz = 1'b0;
		wr   = 1'b1;
		z    = req_item.zero_in;
		n    = req_item.sub_in;
		h    = req_item.half_in;
		c    = req_item.carry_in;
		unique case (op)
			OP_ADD, OP_ADC: begin
				r8 = add9[BYTE_W-1:0]; h = add_nib[4]; c = add9[BYTE_W];
				n = 1'b0; setz = 1'b1;
			end
			OP_SUB, OP_SBC, OP_CP: begin
				r8 = sub9[BYTE_W-1:0]; h = sub_nib[4]; c = sub9[BYTE_W];
				n = 1'b1; setz = 1'b1;
			end
			OP_AND: begin
				r8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0; setz = 1'b1;
			end
			OP_XOR: begin
				r8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
			end
			OP_OR: begin
				r8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
			end
			OP_INC: begin
				r8 = a + BYTE_W'(1); n = 1'b0; h = (a[3:0] == 4'hf); setz = 1'b1;
			end
			OP_DEC: begin
				r8 = a - BYTE_W'(1); n = 1'b1; h = (a[3:0] == 4'h0); setz = 1'b1;
			end
			OP_DAA: begin
				if (!req_item.sub_in) begin
					r8 = a + (daa_hi ? DAA_ADJ_HI : '0) + (daa_lo ? DAA_ADJ_LO : '0);
					c  = req_item.carry_in | daa_hi;
				end else begin
					r8 = a - (req_item.carry_in ? DAA_ADJ_HI : '0)
					       - (req_item.half_in ? DAA_ADJ_LO : '0);
				end
				h = 1'b0; setz = 1'b1;
			end
			OP_CPL: begin
				r8 = ~a; n = 1'b1; h = 1'b1;
			end
			OP_CCF: begin
				r8 = a; n = 1'b0; h = 1'b0; c = ~req_item.carry_in;
			end
			OP_SCF: begin
				r8 = a; n = 1'b0; h = 1'b0; c = 1'b1;
			end
			OP_SWAP: begin
				r8 = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
			end
			OP_BIT: begin
				z = ~|(a & bit_mask); n = 1'b0; h = 1'b1; wr = 1'b0;
			end
			OP_SET: r8 = a | bit_mask;
			OP_RES: r8 = a & ~bit_mask;
			OP_RLC, OP_RLCA: begin
				r8 = {a[6:0], a[7]}; c = a[7];
			end
			OP_RL, OP_RLA: begin
				r8 = {a[6:0], req_item.carry_in}; c = a[7];
			end
			OP_RRC, OP_RRCA: begin
				r8 = {a[0], a[7:1]}; c = a[0];
			end
			OP_RR, OP_RRA: begin
				r8 = {req_item.carry_in, a[7:1]}; c = a[0];
			end
			OP_SLA: begin
				r8 = {a[6:0], 1'b0}; c = a[7];
			end
			OP_SRA: begin
				r8 = {a[7], a[7:1]}; c = a[0];
			end
			OP_SRL: begin
				r8 = {1'b0, a[7:1]}; c = a[0];
			end
			OP_ADD16: begin
				wide = 1'b1; r16 = add17[WORD_W-1:0];
				h = add13[12]; c = add17[WORD_W]; n = 1'b0;
			end
			OP_ADD_SP_E: begin
				wide = 1'b1; r16 = a16 + {{BYTE_W{b[7]}}, b};
				h = sp_nib[4]; c = sp_lo9[BYTE_W]; z = 1'b0; n = 1'b0;
			end
			default: begin
				// unused code: pass operand_a through, no write-back
				wide = 1'b1; r16 = a16; wr = 1'b0;
			end
		endcase

		// rotate/shift group: common flag handling
		if (op == OP_RLC || op == OP_RL || op == OP_RRC || op == OP_RR ||
		    op == OP_SLA || op == OP_SRA || op == OP_SRL) begin
			n = 1'b0; h = 1'b0; z = (r8 == '0);
		end
		if (op == OP_RLCA || op == OP_RLA || op == OP_RRCA || op == OP_RRA) begin
			n = 1'b0; h = 1'b0; z = 1'b0;
		end

		if (setz) z = (r8 == '0);
		if (op == OP_CP) begin
			r8 = '0; wr = 1'b0;
		end
	end

	assign rsp_item.result       = wide ? r16 : {{(WORD_W-BYTE_W){1'b0}}, r8};
	assign rsp_item.write_result = wr;
	assign rsp_item.zero_out     = z;
	assign rsp_item.sub_out      = n;
	assign rsp_item.half_out     = h;
	assign rsp_item.carry_out    = c;

endmodule

FILE: rtl/core/cpu8_alu_with_flags.sv
// Single-pass ALU for an SM83-style 8-bit processor. Each request beat
// carries an operation code, two 16-bit operands (8-bit operations use the
// low byte), a bit index and the incoming Z/N/H/C flags; each response beat
// carries the result, a write-back enable (low for compare, bit test and
// the unused code 31) and the new flags. Flags an operation does not define
// pass through. The block accepts one beat per clock while the sink is not
// stalled; each result passes through the input register and then the
// result register, with the whole datapath between them. The result
// register frees as soon as its beat is taken, so a stalled sink only stops
// new requests once both registers hold a beat.
// ---------------------------------------------------------------------------
// cpu8_alu_with_flags
// Top level: input register, ALU datapath, result register, handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu8_alu_with_flags_defines.svh"

module cpu8_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	c8a_req_if.sink     req,
	c8a_rsp_if.source   rsp
);
	import c8a_pkg::*;

	// Stage 1: input register
	logic      vld_s1;
	req_item_t item_s1;

	// Stage 2: result register
	logic      vld_s2;
	rsp_item_t item_s2;

	rsp_item_t alu_out;
	req_item_t req_item;

	logic s2_free;
	logic s1_free;
	logic s1_adv;

	// The result register takes a new beat when empty or when its beat leaves.
	assign s2_free = !vld_s2 || rsp.ready;
	assign s1_adv  = vld_s1 && s2_free;
	assign s1_free = !vld_s1 || s2_free;

	assign req.ready = s1_free;

	assign req_item.kind      = req.kind;
	assign req_item.operand_a = req.operand_a;
	assign req_item.operand_b = req.operand_b;
	assign req_item.bit_index = req.bit_index;
	assign req_item.zero_in   = req.zero_in;
	assign req_item.sub_in    = req.sub_in;
	assign req_item.half_in   = req.half_in;
	assign req_item.carry_in  = req.carry_in;

	// Capture a request beat whenever stage 1 frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_free) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && req.valid) begin
			item_s1 <= req_item;
		end
	end

	c8a_alu u_alu (
		.req_item (item_s1),
		.rsp_item (alu_out)
	);

	// Advance the datapath output into the result register; hold on stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			item_s2 <= alu_out;
		end
	end

	assign rsp.valid        = vld_s2;
	assign rsp.result       = item_s2.result;
	assign rsp.write_result = item_s2.write_result;
	assign rsp.zero_out     = item_s2.zero_out;
	assign rsp.sub_out      = item_s2.sub_out;
	assign rsp.half_out     = item_s2.half_out;
	assign rsp.carry_out    = item_s2.carry_out;

	// A beat moving out of stage 1 must land in the result register.
	`C8A_ASSERT_NEXT(a_s1_to_s2, s1_adv, vld_s2, "stage 1 beat lost on advance")

	// An empty result register must never stall the request side.
	`C8A_ASSERT_SAME(a_ready_when_s2_empty, !vld_s2, req.ready, "request stalled with empty output")

	// A stage 1 beat blocked by a full result register must stay put.
	`C8A_ASSERT_NEXT(a_s1_hold, vld_s1 && !s2_free, vld_s1, "stage 1 beat dropped under stall")

	// A full result register that is not taken keeps its beat.
	`C8A_ASSERT_NEXT(a_s2_hold, vld_s2 && !rsp.ready, vld_s2, "result beat dropped under stall")

endmodule
